// File: src/ncache_pkg.sv
// Package for the neighbor cache table: transaction payload types, controller
// states and the command and status structs between controller and datapath.
// No dependencies.
package ncache_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int KEY_W       = 64;
  localparam int LINK_W      = 48;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_UPDATE = 1'b1
  } ncache_op_t;

  typedef struct packed {
    logic               command;
    logic [KEY_W-1:0]   addr_high;
    logic [KEY_W-1:0]   addr_low;
    logic [LINK_W-1:0]  new_link_addr;
  } ncache_in_t;

  typedef struct packed {
    logic               hit;
    logic [LINK_W-1:0]  link_addr_out;
  } ncache_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ncache_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ncache_ctl_t;

  typedef struct packed {
    logic scan_done;
  } ncache_sts_t;

endpackage

// File: src/ncache_ctrl.sv
// Controller state machine of the neighbor cache table.
// Depends on ncache_pkg for the state enum and the command and status structs.
module ncache_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output ncache_pkg::ncache_ctl_t ctl,
  input  ncache_pkg::ncache_sts_t sts
);
  import ncache_pkg::*;

  ncache_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        ctl.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/ncache_dpath.sv
// Datapath of the neighbor cache table: entry memories, valid bits, the scan
// counter with its compare stage, and the result register.
// Depends on ncache_pkg for payload types and the command and status structs.
module ncache_dpath #(
  parameter int ENTRIES = ncache_pkg::ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ncache_pkg::ncache_in_t   in_item,
  input  ncache_pkg::ncache_ctl_t  ctl,
  output ncache_pkg::ncache_sts_t  sts,
  output logic                     out_valid,
  output ncache_pkg::ncache_out_t  out_item
);
  import ncache_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);

  logic [KEY_W-1:0]  key_hi_mem [ENTRIES];
  logic [KEY_W-1:0]  key_lo_mem [ENTRIES];
  logic [LINK_W-1:0] link_mem   [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  ncache_in_t        item_r;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              cmp_pend_r;
  logic [KEY_W-1:0]  rd_hi_r;
  logic [KEY_W-1:0]  rd_lo_r;
  logic [LINK_W-1:0] rd_link_r;

  logic              match_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic [LINK_W-1:0] match_link_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;

  logic              out_valid_r;
  ncache_out_t       out_r;

  logic              rd_done;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;
  logic              key_eq;
  logic              cmp_valid_bit;
  logic              do_insert;
  logic              do_refresh;
  logic [IDX_W-1:0]  wr_idx;

  assign rd_done       = (rd_cnt_r == CNT_END);
  assign rd_en         = ctl.step && !rd_done;
  assign rd_idx        = rd_cnt_r[IDX_W-1:0];
  assign key_eq        = (rd_hi_r == item_r.addr_high) && (rd_lo_r == item_r.addr_low);
  assign cmp_valid_bit = valid_r[cmp_idx_r];
  assign sts.scan_done = rd_done && !cmp_pend_r;

  assign do_refresh = ctl.finish && (item_r.command == CMD_UPDATE) && match_r;
  assign do_insert  = ctl.finish && (item_r.command == CMD_UPDATE) && !match_r;
  assign wr_idx     = match_r ? match_idx_r : (free_found_r ? free_idx_r : '0);

  // Entry memories: one registered read port for the scan, one write port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hi_r   <= key_hi_mem[rd_idx];
      rd_lo_r   <= key_lo_mem[rd_idx];
      rd_link_r <= link_mem[rd_idx];
    end
    if (do_insert) begin
      key_hi_mem[wr_idx] <= item_r.addr_high;
      key_lo_mem[wr_idx] <= item_r.addr_low;
    end
    if (do_insert || do_refresh) begin
      link_mem[wr_idx] <= item_r.new_link_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_item;
    end
    if (rd_en) begin
      cmp_idx_r <= rd_idx;
    end
    if (cmp_pend_r && !match_r && cmp_valid_bit && key_eq) begin
      match_idx_r  <= cmp_idx_r;
      match_link_r <= rd_link_r;
    end
    if (ctl.load) begin
      free_idx_r <= '0;
    end else if (cmp_pend_r && !free_found_r && !cmp_valid_bit) begin
      free_idx_r <= cmp_idx_r;
    end
    if (ctl.finish) begin
      out_r.hit <= match_r;
      if (item_r.command == CMD_UPDATE) begin
        out_r.link_addr_out <= item_r.new_link_addr;
      end else if (match_r) begin
        out_r.link_addr_out <= match_link_r;
      end else begin
        out_r.link_addr_out <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      rd_cnt_r     <= '0;
      cmp_pend_r   <= 1'b0;
      match_r      <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= ctl.finish;
      if (do_insert) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (ctl.load) begin
        rd_cnt_r     <= '0;
        cmp_pend_r   <= 1'b0;
        match_r      <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        cmp_pend_r <= rd_en;
        if (rd_en) begin
          rd_cnt_r <= rd_cnt_r + CNT_W'(1);
        end
        if (cmp_pend_r && cmp_valid_bit && key_eq) begin
          match_r <= 1'b1;
        end
        if (cmp_pend_r && !cmp_valid_bit) begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: src/neighbor_cache_table.sv
// Neighbor cache table: maps 128-bit IPv6 addresses to 48-bit link addresses.
// One transaction is taken when start is high and busy is low. The table then
// walks its entries one per cycle through a single registered memory read port,
// compares each read entry in a registered stage, and then registers the result
// and its strobe in the finish state. Busy falls in the same cycle as the strobe,
// so the next transaction can be taken then; none is taken while one is in flight.
// The result is on out_item for exactly one cycle with out_valid high; the
// receiver cannot stall it, so it must capture every strobed result.
// Instantiates ncache_ctrl and ncache_dpath; depends on ncache_pkg.
module neighbor_cache_table #(
  parameter int ENTRIES = ncache_pkg::ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  ncache_pkg::ncache_in_t  in_item,
  output logic                    out_valid,
  output ncache_pkg::ncache_out_t out_item
);
  import ncache_pkg::*;

  ncache_ctl_t ctl;
  ncache_sts_t sts;

  ncache_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .sts   (sts)
  );

  ncache_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
